>>> hw/rtl/cpio_pkg.sv
// ----------------------------------------------------------------------------
// cpio_pkg
// Shared types and constants for the controller port I/O register block.
// ----------------------------------------------------------------------------
package cpio_pkg;

    // Operation codes
    localparam logic [2:0] OP_RD_BYTE = 3'd0;
    localparam logic [2:0] OP_RD_WORD = 3'd1;
    localparam logic [2:0] OP_WR_BYTE = 3'd2;
    localparam logic [2:0] OP_WR_WORD = 3'd3;
    localparam logic [2:0] OP_BUTTON  = 3'd4;

    // Decoded offsets, one bit wider than the bus offset so that the second
    // byte of a word access at the last offset stays out of the decode
    localparam logic [5:0] OFS_A_DATA = 6'h03;
    localparam logic [5:0] OFS_B_DATA = 6'h05;
    localparam logic [5:0] OFS_A_DIR  = 6'h09;
    localparam logic [5:0] OFS_B_DIR  = 6'h0B;

    // Reset values and fixed read values
    localparam logic [7:0] LATCH_RESET    = 8'h7F;
    localparam logic [7:0] DIR_RESET      = 8'h00;
    localparam logic [7:0] BUTTONS_RESET  = 8'hFF;
    localparam logic [7:0] UNDECODED_BYTE = 8'hFF;

    // Port A select line within the data latch
    localparam int SELECT_BIT = 6;

    // One bus or button transaction
    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  offset;
        logic [15:0] write_data;
        logic [2:0]  button;
        logic        pressed;
    } cpio_item_t;

    // Architectural state of both ports and the button store
    typedef struct packed {
        logic [7:0] a_latch;
        logic [7:0] b_latch;
        logic [7:0] a_dir;
        logic [7:0] b_dir;
        logic [7:0] buttons;
    } cpio_state_t;

endpackage

>>> hw/rtl/cpio_in_reg.sv
// ----------------------------------------------------------------------------
// cpio_in_reg
// Input register: captures one transaction and releases it to the core
// once the result side can take it.
// ----------------------------------------------------------------------------
module cpio_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [2:0]          operation,
    input  logic [4:0]          offset,
    input  logic [15:0]         write_data,
    input  logic [2:0]          button,
    input  logic                pressed,
    input  logic                has_result,
    input  logic                out_free,
    output cpio_pkg::cpio_item_t item,
    output logic                fire
);

    logic                 valid_reg;
    logic                 valid_next;
    cpio_pkg::cpio_item_t item_reg;
    logic                 accept;

    // Retire the held transaction; a read also needs room in the output stage
    assign fire      = valid_reg && (!has_result || out_free);
    assign req_stall = valid_reg && !fire;
    assign accept    = req_valid && !req_stall;
    assign item      = item_reg;

    // Advance the valid flag
    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation  <= operation;
            item_reg.offset     <= offset;
            item_reg.write_data <= write_data;
            item_reg.button     <= button;
            item_reg.pressed    <= pressed;
        end
    end

endmodule

>>> hw/rtl/cpio_core.sv
// ----------------------------------------------------------------------------
// cpio_core
// Port registers and button store: decodes the held transaction, updates
// state on retire and forms the read data.
// ----------------------------------------------------------------------------
module cpio_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpio_pkg::cpio_item_t item,
    input  logic                 fire,
    output logic                 has_result,
    output logic [15:0]          rsp_data,
    output cpio_pkg::cpio_state_t state
);

    cpio_pkg::cpio_state_t state_reg;
    cpio_pkg::cpio_state_t state_next;
    logic [5:0]            ofs0;
    logic [5:0]            ofs1;
    logic                  wr_en;
    logic                  wr_word;
    logic [7:0]            byte0;
    logic [7:0]            byte1;
    logic [8:0]            wr_a_data;
    logic [8:0]            wr_b_data;
    logic [8:0]            wr_a_dir;
    logic [8:0]            wr_b_dir;
    logic [7:0]            rd_hi;
    logic [7:0]            rd_lo;

    // Active-low pad byte seen on port A, with output bits from the latch
    function automatic logic [7:0] pad_byte(cpio_pkg::cpio_state_t s);
        logic [7:0] v;
        if (s.a_latch[cpio_pkg::SELECT_BIT])
        begin
            v = {2'b01, s.buttons[5:0]};
        end
        else
        begin
            v = {2'b00, s.buttons[7], s.buttons[6], 2'b00, s.buttons[1:0]};
        end
        return (v & ~s.a_dir) | (s.a_latch & s.a_dir);
    endfunction

    // Byte read at one decoded offset
    function automatic logic [7:0] read_byte(logic [5:0] ofs,
                                             cpio_pkg::cpio_state_t s);
        logic [7:0] d;
        case (ofs)
            cpio_pkg::OFS_A_DATA: d = pad_byte(s);
            cpio_pkg::OFS_B_DATA: d = s.b_latch;
            cpio_pkg::OFS_A_DIR:  d = s.a_dir;
            cpio_pkg::OFS_B_DIR:  d = s.b_dir;
            default:              d = cpio_pkg::UNDECODED_BYTE;
        endcase
        return d;
    endfunction

    // Write hit and data for one register: {hit, byte}
    function automatic logic [8:0] write_sel(logic [5:0] addr, logic en, logic word,
                                             logic [5:0] a0, logic [5:0] a1,
                                             logic [7:0] d0, logic [7:0] d1);
        logic [8:0] r;
        if (en && (a0 == addr))
        begin
            r = {1'b1, d0};
        end
        else if (en && word && (a1 == addr))
        begin
            r = {1'b1, d1};
        end
        else
        begin
            r = {1'b0, d0};
        end
        return r;
    endfunction

    assign state = state_reg;
    assign ofs0  = {1'b0, item.offset};
    assign ofs1  = ofs0 + 6'd1;

    // Decode the operation
    always_comb
    begin
        has_result = 1'b0;
        wr_en      = 1'b0;
        wr_word    = 1'b0;
        case (item.operation)
            cpio_pkg::OP_RD_BYTE: has_result = 1'b1;
            cpio_pkg::OP_RD_WORD: has_result = 1'b1;
            cpio_pkg::OP_WR_BYTE: wr_en      = fire;
            cpio_pkg::OP_WR_WORD:
            begin
                wr_en   = fire;
                wr_word = 1'b1;
            end
            default: has_result = 1'b0;
        endcase
    end

    // Word writes put the high byte at the offset, the low byte one above
    assign byte0 = wr_word ? item.write_data[15:8] : item.write_data[7:0];
    assign byte1 = item.write_data[7:0];

    assign wr_a_data = write_sel(cpio_pkg::OFS_A_DATA, wr_en, wr_word, ofs0, ofs1, byte0, byte1);
    assign wr_b_data = write_sel(cpio_pkg::OFS_B_DATA, wr_en, wr_word, ofs0, ofs1, byte0, byte1);
    assign wr_a_dir  = write_sel(cpio_pkg::OFS_A_DIR,  wr_en, wr_word, ofs0, ofs1, byte0, byte1);
    assign wr_b_dir  = write_sel(cpio_pkg::OFS_B_DIR,  wr_en, wr_word, ofs0, ofs1, byte0, byte1);

    // Next state: masked latch writes, direction writes, button events
    always_comb
    begin
        state_next = state_reg;
        if (wr_a_data[8])
        begin
            state_next.a_latch = (state_reg.a_latch & ~state_reg.a_dir) |
                                 (wr_a_data[7:0] & state_reg.a_dir);
        end
        if (wr_b_data[8])
        begin
            state_next.b_latch = (state_reg.b_latch & ~state_reg.b_dir) |
                                 (wr_b_data[7:0] & state_reg.b_dir);
        end
        if (wr_a_dir[8])
        begin
            state_next.a_dir = wr_a_dir[7:0];
        end
        if (wr_b_dir[8])
        begin
            state_next.b_dir = wr_b_dir[7:0];
        end
        if (fire && (item.operation == cpio_pkg::OP_BUTTON))
        begin
            state_next.buttons[item.button] = !item.pressed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.a_latch <= cpio_pkg::LATCH_RESET;
            state_reg.b_latch <= cpio_pkg::LATCH_RESET;
            state_reg.a_dir   <= cpio_pkg::DIR_RESET;
            state_reg.b_dir   <= cpio_pkg::DIR_RESET;
            state_reg.buttons <= cpio_pkg::BUTTONS_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Form read data; a byte read leaves the high byte zero
    assign rd_hi = read_byte(ofs0, state_reg);
    assign rd_lo = read_byte(ofs1, state_reg);

    always_comb
    begin
        if (item.operation == cpio_pkg::OP_RD_WORD)
        begin
            rsp_data = {rd_hi, rd_lo};
        end
        else
        begin
            rsp_data = {8'h00, rd_hi};
        end
    end

endmodule

>>> hw/rtl/cpio_out_reg.sv
// ----------------------------------------------------------------------------
// cpio_out_reg
// Output register: holds one read result until the consumer takes it.
// ----------------------------------------------------------------------------
module cpio_out_reg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [15:0] data,
    input  logic        rsp_stall,
    output logic        rsp_valid,
    output logic [15:0] read_data,
    output logic        out_free
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] data_reg;

    // Free when empty or when the held result leaves this cycle
    assign out_free  = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign read_data = data_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until a new one loads
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

endmodule

>>> hw/rtl/controller_port_io_registers.sv
// A read transaction goes through the input register, then the output register.
// Throughput: one transaction per cycle; the input register retires a held
// transaction each cycle unless a read waits on a full, stalled output register.
// Reset (rst_n, asynchronous, active low): port latches 0x7F, directions 0x00,
// all buttons released, no transaction held and no result pending.
// ----------------------------------------------------------------------------
// controller_port_io_registers
// Two controller port register pairs with a button store, behind a bus-style
// transaction channel and a read result channel.
// ----------------------------------------------------------------------------
module controller_port_io_registers
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  operation,
    input  logic [4:0]  offset,
    input  logic [15:0] write_data,
    input  logic [2:0]  button,
    input  logic        pressed,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [15:0] read_data
);

    cpio_pkg::cpio_item_t  item;
    cpio_pkg::cpio_state_t state;
    logic                  fire;
    logic                  has_result;
    logic                  out_free;
    logic [15:0]           rsp_data;

    cpio_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .operation  (operation),
        .offset     (offset),
        .write_data (write_data),
        .button     (button),
        .pressed    (pressed),
        .has_result (has_result),
        .out_free   (out_free),
        .item       (item),
        .fire       (fire)
    );

    cpio_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .fire       (fire),
        .has_result (has_result),
        .rsp_data   (rsp_data),
        .state      (state)
    );

    cpio_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && has_result),
        .data      (rsp_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .read_data (read_data),
        .out_free  (out_free)
    );

`ifndef ASSERT_OFF
    // A retired read always shows up as a pending result
    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && has_result) |=> rsp_valid)
        else $error("retired read did not load the output register");

    // The button store only moves on a retired button event
    a_buttons_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && (item.operation == cpio_pkg::OP_BUTTON)) |=> $stable(state.buttons))
        else $error("button store changed without a button event");

    // Port B latch bits configured as inputs never change
    a_b_inputs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((state.b_latch & ~$past(state.b_dir)) ==
                  ($past(state.b_latch) & ~$past(state.b_dir))))
        else $error("port B input bit changed");
`endif

endmodule
